// ===== rtl/adc_scan_phase_emf_sequencer_top_macros.svh =====
`ifndef ADC_SCAN_PHASE_EMF_SEQUENCER_TOP_MACROS_SVH
`define ADC_SCAN_PHASE_EMF_SEQUENCER_TOP_MACROS_SVH

// invariant checked on every edge out of reset
`define ASPES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition on one edge implies a consequence on the next
`define ASPES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aspes_pkg.sv =====
package aspes_pkg;

    localparam int RAW_W     = 16;
    localparam int SMP_W     = 10;
    localparam int SUM_W     = 13;
    localparam int STEP_W    = 3;
    localparam int SLOT_W    = 2;
    localparam int N_SLOTS   = 4;
    localparam int AVG_SHIFT = 3;
    localparam int RED_SHIFT = 2;

    localparam logic [SMP_W-1:0]  LOW10_MASK = 10'h3FF;
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd7;
    localparam logic [SLOT_W-1:0] SLOT_LAST  = 2'd3;

    typedef logic [SMP_W-1:0] sample_t;
    typedef logic [N_SLOTS-1:0][SMP_W-1:0] slot_set_t;

    typedef struct packed {
        sample_t mid_ref;
        sample_t emf_peak;
        sample_t diff_amp;
        sample_t break_switch;
        sample_t supply12;
        sample_t supply3;
        sample_t phase_one;
        sample_t phase_two;
        sample_t phase_three;
        sample_t phase_four;
        sample_t emf_average;
        logic    self_trigger;
    } result_t;

    function automatic sample_t reduce10(input logic [RAW_W-1:0] raw);
        logic [RAW_W-1:0] shifted;
        shifted = raw >> RED_SHIFT;
        return shifted[SMP_W-1:0] & LOW10_MASK;
    endfunction

endpackage

// ===== rtl/aspes_core.sv =====
`include "adc_scan_phase_emf_sequencer_top_macros.svh"

module aspes_core
    import aspes_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [RAW_W-1:0] phase_raw,
    input  logic [RAW_W-1:0] mid_ref_raw,
    input  logic [RAW_W-1:0] emf_raw,
    input  logic [RAW_W-1:0] diff_amp_raw,
    input  logic [RAW_W-1:0] break_switch_raw,
    input  logic [RAW_W-1:0] supply12_raw,
    input  logic [RAW_W-1:0] supply3_raw,
    output result_t          res
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    slot_set_t         slots_reg;
    slot_set_t         slots_next;
    slot_set_t         pub_reg;
    slot_set_t         pub_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_add;
    sample_t           avg_reg;
    sample_t           avg_next;
    sample_t           phase;
    sample_t           emf;
    logic [SLOT_W-1:0] slot;

    assign phase = reduce10(phase_raw);
    assign emf   = reduce10(emf_raw);
    assign slot  = step_reg[SLOT_W-1:0];

    always_comb
    begin
        slots_next       = slots_reg;
        slots_next[slot] = phase;
        pub_next         = (slot == SLOT_LAST) ? slots_next : pub_reg;
        sum_add          = (step_reg == STEP_FIRST) ? SUM_W'(emf) : sum_reg + SUM_W'(emf);
        if (step_reg == STEP_LAST)
        begin
            sum_next = '0;
            avg_next = sum_add[SUM_W-1:AVG_SHIFT];
        end
        else
        begin
            sum_next = sum_add;
            avg_next = avg_reg;
        end
        step_next = step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_FIRST;
            slots_reg <= '0;
            pub_reg   <= '0;
            sum_reg   <= '0;
            avg_reg   <= '0;
        end
        else if (fire)
        begin
            step_reg  <= step_next;
            slots_reg <= slots_next;
            pub_reg   <= pub_next;
            sum_reg   <= sum_next;
            avg_reg   <= avg_next;
        end
    end

    always_comb
    begin
        res.mid_ref      = reduce10(mid_ref_raw);
        res.emf_peak     = emf;
        res.diff_amp     = reduce10(diff_amp_raw);
        res.break_switch = reduce10(break_switch_raw);
        res.supply12     = reduce10(supply12_raw);
        res.supply3      = reduce10(supply3_raw);
        res.phase_one    = pub_next[0];
        res.phase_two    = pub_next[1];
        res.phase_three  = pub_next[2];
        res.phase_four   = pub_next[3];
        res.emf_average  = avg_next;
        res.self_trigger = (slot != SLOT_LAST);
    end

    `ASPES_ASSERT_NEXT(a_idle_holds, !fire, $stable(step_reg) && $stable(sum_reg), "state moved without a beat")
    `ASPES_ASSERT_NEXT(a_wrap_clears, fire && step_reg == STEP_LAST, step_reg == STEP_FIRST && sum_reg == '0, "step eight did not wrap and clear the sum")
    `ASPES_ASSERT_NEXT(a_pub_last, fire && slot == SLOT_LAST, pub_reg[SLOT_LAST] == $past(phase), "published set lacks the current phase")

endmodule

// ===== rtl/aspes_outbuf.sv =====
`include "adc_scan_phase_emf_sequencer_top_macros.svh"

module aspes_outbuf
    import aspes_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t d,
    output logic    ready,
    output logic    q_valid,
    input  logic    q_ready,
    output result_t q
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    out_free;

    assign ready    = !skid_valid_reg;
    assign q_valid  = out_valid_reg;
    assign q        = out_data_reg;
    assign out_free = !out_valid_reg || q_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            // skid drains first to keep order
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push ? d : out_data_reg;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `ASPES_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid holds a beat ahead of the output")
    `ASPES_ASSERT(a_no_overrun, !(push && skid_valid_reg), "beat pushed into a full buffer")
    `ASPES_ASSERT_NEXT(a_skid_drain, skid_valid_reg && q_ready, out_valid_reg && out_data_reg == $past(skid_data_reg), "skid beat lost on drain")

endmodule

// ===== rtl/adc_scan_phase_emf_sequencer_top.sv =====
// an accepted scan is registered at the output, or in the skid entry on a stall
// throughput: one scan per cycle, output side stalls absorbed by a two-beat buffer
// in_ready drops only while both buffer entries hold beats
// reset (async, active low) clears the step counter to step one, phase slots,
// published phases, emf sum and average, and empties the output buffer
module adc_scan_phase_emf_sequencer_top
    import aspes_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [RAW_W-1:0] phase_raw,
    input  logic [RAW_W-1:0] mid_ref_raw,
    input  logic [RAW_W-1:0] emf_raw,
    input  logic [RAW_W-1:0] diff_amp_raw,
    input  logic [RAW_W-1:0] break_switch_raw,
    input  logic [RAW_W-1:0] supply12_raw,
    input  logic [RAW_W-1:0] supply3_raw,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SMP_W-1:0] mid_ref,
    output logic [SMP_W-1:0] emf_peak,
    output logic [SMP_W-1:0] diff_amp,
    output logic [SMP_W-1:0] break_switch,
    output logic [SMP_W-1:0] supply12,
    output logic [SMP_W-1:0] supply3,
    output logic [SMP_W-1:0] phase_one,
    output logic [SMP_W-1:0] phase_two,
    output logic [SMP_W-1:0] phase_three,
    output logic [SMP_W-1:0] phase_four,
    output logic [SMP_W-1:0] emf_average,
    output logic             self_trigger
);

    logic    fire;
    result_t res;
    result_t q;

    assign fire = in_valid && in_ready;

    aspes_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (fire),
        .phase_raw        (phase_raw),
        .mid_ref_raw      (mid_ref_raw),
        .emf_raw          (emf_raw),
        .diff_amp_raw     (diff_amp_raw),
        .break_switch_raw (break_switch_raw),
        .supply12_raw     (supply12_raw),
        .supply3_raw      (supply3_raw),
        .res              (res)
    );

    aspes_outbuf u_outbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fire),
        .d       (res),
        .ready   (in_ready),
        .q_valid (out_valid),
        .q_ready (out_ready),
        .q       (q)
    );

    assign mid_ref      = q.mid_ref;
    assign emf_peak     = q.emf_peak;
    assign diff_amp     = q.diff_amp;
    assign break_switch = q.break_switch;
    assign supply12     = q.supply12;
    assign supply3      = q.supply3;
    assign phase_one    = q.phase_one;
    assign phase_two    = q.phase_two;
    assign phase_three  = q.phase_three;
    assign phase_four   = q.phase_four;
    assign emf_average  = q.emf_average;
    assign self_trigger = q.self_trigger;

endmodule

// ===== verif/tb.sv =====
module tb;
    import aspes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [RAW_W-1:0] phase;
        logic [RAW_W-1:0] mid;
        logic [RAW_W-1:0] emf;
        logic [RAW_W-1:0] diff;
        logic [RAW_W-1:0] brk;
        logic [RAW_W-1:0] s12;
        logic [RAW_W-1:0] s3;
    } scan_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [RAW_W-1:0] phase_raw = '0;
    logic [RAW_W-1:0] mid_ref_raw = '0;
    logic [RAW_W-1:0] emf_raw = '0;
    logic [RAW_W-1:0] diff_amp_raw = '0;
    logic [RAW_W-1:0] break_switch_raw = '0;
    logic [RAW_W-1:0] supply12_raw = '0;
    logic [RAW_W-1:0] supply3_raw = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [SMP_W-1:0] mid_ref;
    logic [SMP_W-1:0] emf_peak;
    logic [SMP_W-1:0] diff_amp;
    logic [SMP_W-1:0] break_switch;
    logic [SMP_W-1:0] supply12;
    logic [SMP_W-1:0] supply3;
    logic [SMP_W-1:0] phase_one;
    logic [SMP_W-1:0] phase_two;
    logic [SMP_W-1:0] phase_three;
    logic [SMP_W-1:0] phase_four;
    logic [SMP_W-1:0] emf_average;
    logic             self_trigger;

    adc_scan_phase_emf_sequencer_top dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // sequencer state mirrored on the testbench side
    logic [STEP_W-1:0] step_idx = STEP_FIRST;
    slot_set_t         slot_mem = '0;
    slot_set_t         shown_phases = '0;
    logic [SUM_W-1:0]  emf_acc = '0;
    sample_t           avg_held = '0;

    scan_t   scan_backlog[$];
    result_t pending_readouts[$];
    scan_t   cur_scan;
    result_t want;

    int total_scans = 0;
    int scans_taken = 0;
    int readouts_seen = 0;
    int publications_seen = 0;
    int error_count = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;
    int recv_cycles = 0;
    int hold_left = 0;
    int hold_total = 0;

    function automatic sample_t trim10(input logic [RAW_W-1:0] raw);
        return raw[SMP_W+1:2];
    endfunction

    function automatic result_t sequence_scan(input scan_t s);
        result_t r;
        sample_t ph;
        sample_t em;
        logic    trig;
        ph = trim10(s.phase);
        em = trim10(s.emf);
        trig = 1'b1;
        slot_mem[step_idx[SLOT_W-1:0]] = ph;
        if (step_idx == STEP_FIRST)
            emf_acc = SUM_W'(em);
        else
            emf_acc = emf_acc + SUM_W'(em);
        if (step_idx[SLOT_W-1:0] == SLOT_LAST)
        begin
            shown_phases = slot_mem;
            trig = 1'b0;
        end
        if (step_idx == STEP_LAST)
        begin
            avg_held = emf_acc[SUM_W-1:AVG_SHIFT];
            emf_acc = '0;
        end
        step_idx = step_idx + 1'b1;
        r.mid_ref      = trim10(s.mid);
        r.emf_peak     = em;
        r.diff_amp     = trim10(s.diff);
        r.break_switch = trim10(s.brk);
        r.supply12     = trim10(s.s12);
        r.supply3      = trim10(s.s3);
        r.phase_one    = shown_phases[0];
        r.phase_two    = shown_phases[1];
        r.phase_three  = shown_phases[2];
        r.phase_four   = shown_phases[3];
        r.emf_average  = avg_held;
        r.self_trigger = trig;
        return r;
    endfunction

    // mostly short gaps, some long ones, and calm stretches with none
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [RAW_W-1:0] rand_raw();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF - 16'($urandom_range(0, 3));
            1: return 16'($urandom_range(0, 7));
            2: return 16'h0FFC | 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_scan(input logic [RAW_W-1:0] ph, input logic [RAW_W-1:0] md,
                            input logic [RAW_W-1:0] em, input logic [RAW_W-1:0] df,
                            input logic [RAW_W-1:0] bk, input logic [RAW_W-1:0] hi,
                            input logic [RAW_W-1:0] lo);
        scan_t s;
        s.phase = ph;
        s.mid = md;
        s.emf = em;
        s.diff = df;
        s.brk = bk;
        s.s12 = hi;
        s.s3 = lo;
        scan_backlog.push_back(s);
        total_scans++;
    endtask

    task automatic check_field(input string label, input sample_t want_v, input sample_t got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", label, want_v, got_v);
            error_count++;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_readouts.push_back(sequence_scan(cur_scan));
                scans_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (scan_backlog.size() > 0)
                begin
                    cur_scan = scan_backlog.pop_front();
                    phase_raw        <= cur_scan.phase;
                    mid_ref_raw      <= cur_scan.mid;
                    emf_raw          <= cur_scan.emf;
                    diff_amp_raw     <= cur_scan.diff;
                    break_switch_raw <= cur_scan.brk;
                    supply12_raw     <= cur_scan.s12;
                    supply3_raw      <= cur_scan.s3;
                    in_valid <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with long hold-offs to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            recv_cycles++;
            if (recv_cycles % 2500 == 1000)
                hold_left = $urandom_range(100, 200);
            if (hold_left > 0)
            begin
                hold_left--;
                hold_total++;
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_stall = pick_gap(recv_calm);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            readouts_seen++;
            if (pending_readouts.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                error_count++;
            end
            else
            begin
                want = pending_readouts.pop_front();
                if (!want.self_trigger)
                    publications_seen++;
                check_field("mid_ref", want.mid_ref, mid_ref);
                check_field("emf_peak", want.emf_peak, emf_peak);
                check_field("diff_amp", want.diff_amp, diff_amp);
                check_field("break_switch", want.break_switch, break_switch);
                check_field("supply12", want.supply12, supply12);
                check_field("supply3", want.supply3, supply3);
                check_field("phase_one", want.phase_one, phase_one);
                check_field("phase_two", want.phase_two, phase_two);
                check_field("phase_three", want.phase_three, phase_three);
                check_field("phase_four", want.phase_four, phase_four);
                check_field("emf_average", want.emf_average, emf_average);
                check_field("self_trigger", SMP_W'(want.self_trigger), SMP_W'(self_trigger));
            end
        end
    end

    initial
    begin
        logic [RAW_W-1:0] pats[8];
        pats = '{16'hAAAA, 16'h5555, 16'h0003, 16'hFFFC,
                 16'h8000, 16'h0004, 16'h7FFF, 16'h1000};
        // full scale on every channel but phase: largest emf sum and average
        for (int k = 0; k < 8; k++)
            add_scan(16'((k * 100 + 7) << 2), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF);
        // all zero apart from a slot marker on phase
        for (int k = 0; k < 8; k++)
            add_scan(16'((k + 1) << 2), 16'h0000, 16'h0000, 16'h0000,
                     16'h0000, 16'h0000, 16'h0000);
        // bit patterns rotating across channels
        for (int k = 0; k < 8; k++)
            add_scan(pats[k % 8], pats[(k + 1) % 8], pats[(k + 2) % 8], pats[(k + 3) % 8],
                     pats[(k + 4) % 8], pats[(k + 5) % 8], pats[(k + 6) % 8]);
        for (int k = 0; k < 750; k++)
            add_scan(rand_raw(), rand_raw(), rand_raw(), rand_raw(),
                     rand_raw(), rand_raw(), rand_raw());

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (scans_taken < total_scans || pending_readouts.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d scans checked, %0d phase publications, %0d eight-scan averages",
                 readouts_seen, publications_seen, publications_seen / 2);
        $display("tb: output side held off for %0d cycles in long stretches", hold_total);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/aspes_pkg.sv
rtl/aspes_core.sv
rtl/aspes_outbuf.sv
rtl/adc_scan_phase_emf_sequencer_top.sv
verif/tb.sv
